// ===== sv/nqcc_pkg.sv =====
// Shared types, constants and shift helpers for the N-queens constellation counter.
// No dependencies; imported by every module of the block.
package nqcc_pkg;

    localparam int MAX_BOARD = 32;
    localparam int MIN_BOARD = 6;
    localparam int ROW_W     = 5;
    localparam int MASK_W    = 32;
    localparam int COUNT_W   = 48;
    localparam int CFG_W     = 6;
    localparam int IN_W      = 120;

    localparam logic [CFG_W-1:0] BOARD_RESET = CFG_W'(16);

    typedef logic [ROW_W-1:0]   row_t;
    typedef logic [MASK_W-1:0]  mask_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [CFG_W-1:0]   size_t;

    localparam count_t COUNT_MAX = '1;

    // Input beat, ld in the lowest bits.
    typedef struct packed {
        logic [3:0] pad;
        row_t       queen_l;
        row_t       queen_k;
        row_t       queen_j;
        row_t       start_row;
        mask_t      column_mask;
        mask_t      right_diag_mask;
        mask_t      left_diag_mask;
    } in_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BUILD,
        S_CHECK,
        S_FETCH_TBL,
        S_STEP,
        S_FETCH_STK,
        S_DONE
    } eng_state_t;

    typedef struct packed {
        mask_t freem;
        mask_t q;
    } stk_entry_t;

    typedef struct packed {
        logic  we;
        row_t  waddr;
        mask_t wdata;
        logic  re;
        row_t  raddr;
    } tbl_req_t;

    typedef struct packed {
        logic       we;
        row_t       waddr;
        stk_entry_t wdata;
        logic       re;
        row_t       raddr;
    } stk_req_t;

    // Shifts that give zero for a negative amount or an amount past bit 31.
    function automatic mask_t shr32(mask_t x, logic signed [7:0] s);
        if (s < 8'sd0 || s > 8'sd31) begin
            return '0;
        end
        return x >> s[4:0];
    endfunction

    function automatic mask_t shl32(mask_t x, logic signed [7:0] s);
        if (s < 8'sd0 || s > 8'sd31) begin
            return '0;
        end
        return x << s[4:0];
    endfunction

    // Blocking mask of one row, built from the border queens.
    function automatic mask_t row_block(row_t a, size_t n, row_t k, row_t l, mask_t top_bit,
                                        mask_t lbot, mask_t rbot, mask_t ltop, mask_t rtop);
        logic signed [7:0] sh_n;
        logic signed [7:0] sh_a;
        mask_t             v;
        sh_n = $signed({2'b00, n}) - 8'sd1 - $signed({3'b000, a});
        sh_a = $signed({3'b000, a});
        v    = '0;
        if ({1'b0, a} < n) begin
            if (a == k || a == l) begin
                if (a == k) v = v + ~top_bit;
                if (a == l) v = v + ~mask_t'(1);
            end else begin
                v = shr32(lbot, sh_n) | shl32(rbot, sh_n) | shl32(ltop, sh_a)
                  | shr32(rtop, sh_a) | top_bit | mask_t'(1);
            end
        end
        return v;
    endfunction

endpackage

// ===== sv/nqcc_table_ram.sv =====
// Row blocking table: one write port and one read port, registered read data.
// Depends on nqcc_pkg.
module nqcc_table_ram
    import nqcc_pkg::*;
(
    input  logic     aclk,
    input  tbl_req_t req,
    output mask_t    rdata
);

    mask_t mem [MAX_BOARD];
    mask_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) mem[req.waddr] <= req.wdata;
        if (req.re) rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/nqcc_stack_ram.sv =====
// Per-row backtracking stack: queen and remaining free mask of each placed row.
// Depends on nqcc_pkg.
module nqcc_stack_ram
    import nqcc_pkg::*;
(
    input  logic       aclk,
    input  stk_req_t   req,
    output stk_entry_t rdata
);

    stk_entry_t mem [MAX_BOARD];
    stk_entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) mem[req.waddr] <= req.wdata;
        if (req.re) rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/nqcc_engine.sv =====
// Sequencer and datapath: table build, bitmask backtracking, result register.
// Depends on nqcc_pkg; drives the table and stack memories through request structs.
module nqcc_engine
    import nqcc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  size_t      cfg_wdata,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  in_item_t   s_item,
    output logic       m_tvalid,
    input  logic       m_tready,
    output count_t     m_count,
    output tbl_req_t   tbl_req,
    input  mask_t      tbl_rdata,
    output stk_req_t   stk_req,
    input  stk_entry_t stk_rdata
);

    eng_state_t state_reg, state_next;
    size_t      board_size_reg;
    logic       m_valid_reg, m_valid_next;
    count_t     m_count_reg, m_count_next;

    size_t  n_reg, n_next;
    mask_t  top_reg, top_next;
    mask_t  ld_reg, ld_next;
    mask_t  rd_reg, rd_next;
    mask_t  col_reg, col_next;
    mask_t  lbot_reg, lbot_next;
    mask_t  rbot_reg, rbot_next;
    mask_t  ltop_reg, ltop_next;
    mask_t  rtop_reg, rtop_next;
    row_t   start_reg, start_next;
    row_t   k_reg, k_next;
    row_t   l_reg, l_next;
    row_t   build_idx_reg, build_idx_next;
    row_t   row_reg, row_next;
    mask_t  free_reg, free_next;
    mask_t  ls_reg, ls_next;
    mask_t  rs_reg, rs_next;
    count_t count_reg, count_next;

    size_t  n_in;
    mask_t  top_in;
    mask_t  q_low;
    size_t  last_row;
    logic   no_rows;
    logic   at_last;
    logic   slot_free;

    assign last_row  = n_reg - size_t'(2);
    assign no_rows   = {1'b0, start_reg} > last_row;
    assign at_last   = {1'b0, row_reg} == last_row;
    assign q_low     = free_reg & (~free_reg + mask_t'(1));
    assign slot_free = !m_valid_reg || m_tready;

    // Clamp the configured size into the legal range.
    always_comb begin
        if (board_size_reg < size_t'(MIN_BOARD)) begin
            n_in = size_t'(MIN_BOARD);
        end else if (board_size_reg > size_t'(MAX_BOARD)) begin
            n_in = size_t'(MAX_BOARD);
        end else begin
            n_in = board_size_reg;
        end
        top_in = shl32(mask_t'(1), $signed({2'b00, n_in}) - 8'sd1);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (s_tvalid) state_next = S_BUILD;
            S_BUILD:     if (build_idx_reg == row_t'(MAX_BOARD - 1)) state_next = S_CHECK;
            S_CHECK:     state_next = no_rows ? S_DONE : S_FETCH_TBL;
            S_FETCH_TBL: state_next = S_STEP;
            S_STEP: begin
                if (free_reg != '0) begin
                    state_next = at_last ? S_STEP : S_FETCH_TBL;
                end else begin
                    state_next = (row_reg == start_reg) ? S_DONE : S_FETCH_STK;
                end
            end
            S_FETCH_STK: state_next = S_STEP;
            S_DONE:      if (slot_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // Handshake outputs and result register
    always_comb begin
        s_tready     = (state_reg == S_IDLE);
        m_valid_next = m_valid_reg && !m_tready;
        m_count_next = m_count_reg;
        if (state_reg == S_DONE && slot_free) begin
            m_valid_next = 1'b1;
            m_count_next = count_reg;
        end
    end

    // Datapath and memory requests
    always_comb begin
        n_next         = n_reg;
        top_next       = top_reg;
        ld_next        = ld_reg;
        rd_next        = rd_reg;
        col_next       = col_reg;
        lbot_next      = lbot_reg;
        rbot_next      = rbot_reg;
        ltop_next      = ltop_reg;
        rtop_next      = rtop_reg;
        start_next     = start_reg;
        k_next         = k_reg;
        l_next         = l_reg;
        build_idx_next = build_idx_reg;
        row_next       = row_reg;
        free_next      = free_reg;
        ls_next        = ls_reg;
        rs_next        = rs_reg;
        count_next     = count_reg;
        tbl_req        = '0;
        stk_req        = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    n_next         = n_in;
                    top_next       = top_in;
                    ld_next        = s_item.left_diag_mask;
                    rd_next        = s_item.right_diag_mask;
                    col_next       = ~(top_in - mask_t'(2)) ^ s_item.column_mask;
                    lbot_next      = shr32(top_in, $signed({3'b000, s_item.queen_j}))
                                   | shr32(top_in, $signed({3'b000, s_item.queen_l}));
                    rbot_next      = shr32(top_in, $signed({3'b000, s_item.queen_j}))
                                   | shr32(top_in, $signed({2'b00, n_in}) - 8'sd1
                                                   - $signed({3'b000, s_item.queen_k}));
                    ltop_next      = shr32(top_in, $signed({3'b000, s_item.queen_k}));
                    rtop_next      = shl32(mask_t'(1), $signed({3'b000, s_item.queen_l}));
                    start_next     = s_item.start_row;
                    k_next         = s_item.queen_k;
                    l_next         = s_item.queen_l;
                    build_idx_next = '0;
                    ls_next        = '0;
                    rs_next        = '0;
                    count_next     = '0;
                end
            end
            S_BUILD: begin
                tbl_req.we     = 1'b1;
                tbl_req.waddr  = build_idx_reg;
                tbl_req.wdata  = row_block(build_idx_reg, n_reg, k_reg, l_reg, top_reg,
                                           lbot_reg, rbot_reg, ltop_reg, rtop_reg);
                build_idx_next = build_idx_reg + row_t'(1);
            end
            S_CHECK: begin
                if (!no_rows) begin
                    ld_next = ld_reg & ~shl32(ltop_reg, $signed({3'b000, start_reg}));
                    // a right border queen in the last row keeps its diagonal
                    if ({1'b0, l_reg} != n_reg - size_t'(1)) begin
                        rd_next = rd_reg & ~shr32(rtop_reg, $signed({3'b000, start_reg}));
                    end
                    tbl_req.re    = 1'b1;
                    tbl_req.raddr = start_reg;
                    row_next      = start_reg;
                end
            end
            S_FETCH_TBL: begin
                free_next = ~(tbl_rdata | ld_reg | rd_reg | col_reg);
            end
            S_STEP: begin
                if (free_reg != '0) begin
                    if (at_last) begin
                        if (count_reg != COUNT_MAX) count_next = count_reg + count_t'(1);
                        free_next = '0;
                    end else begin
                        // push this row, descend one row
                        stk_req.we          = 1'b1;
                        stk_req.waddr       = row_reg;
                        stk_req.wdata.q     = q_low;
                        stk_req.wdata.freem = free_reg ^ q_low;
                        row_next            = row_reg + row_t'(1);
                        ls_next             = {ls_reg[MASK_W-2:0], ld_reg[MASK_W-1]};
                        rs_next             = {rd_reg[0], rs_reg[MASK_W-1:1]};
                        ld_next             = (ld_reg | q_low) << 1;
                        rd_next             = (rd_reg | q_low) >> 1;
                        col_next            = col_reg ^ q_low;
                        tbl_req.re          = 1'b1;
                        tbl_req.raddr       = row_reg + row_t'(1);
                    end
                end else if (row_reg != start_reg) begin
                    row_next      = row_reg - row_t'(1);
                    stk_req.re    = 1'b1;
                    stk_req.raddr = row_reg - row_t'(1);
                end
            end
            S_FETCH_STK: begin
                // pop: restore the diagonals from the spill registers
                free_next = stk_rdata.freem;
                ld_next   = {ls_reg[0], ld_reg[MASK_W-1:1]} & ~stk_rdata.q;
                rd_next   = {rd_reg[MASK_W-2:0], rs_reg[MASK_W-1]} & ~stk_rdata.q;
                ls_next   = ls_reg >> 1;
                rs_next   = rs_reg << 1;
                col_next  = col_reg ^ stk_rdata.q;
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_valid_reg    <= 1'b0;
            board_size_reg <= BOARD_RESET;
            ls_reg         <= '0;
            rs_reg         <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            ls_reg      <= ls_next;
            rs_reg      <= rs_next;
            if (cfg_we) board_size_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        m_count_reg   <= m_count_next;
        n_reg         <= n_next;
        top_reg       <= top_next;
        ld_reg        <= ld_next;
        rd_reg        <= rd_next;
        col_reg       <= col_next;
        lbot_reg      <= lbot_next;
        rbot_reg      <= rbot_next;
        ltop_reg      <= ltop_next;
        rtop_reg      <= rtop_next;
        start_reg     <= start_next;
        k_reg         <= k_next;
        l_reg         <= l_next;
        build_idx_reg <= build_idx_next;
        row_reg       <= row_next;
        free_reg      <= free_next;
        count_reg     <= count_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_count  = m_count_reg;

endmodule

// ===== sv/nqueens_constellation_counter.sv =====
// N-queens constellation counter, top level.
// Input beat on s_axis (s_tvalid/s_tready/s_tdata): one start constellation.
// Result beat on m_axis (m_tvalid/m_tready/m_tdata): its solution count, 48 bits,
// saturating at all ones. Exactly one result beat per input beat, in order.
// cfg_we/cfg_wdata write board_size (clamped to 6..32 when used); write it while idle.
// One constellation at a time. Per item: rebuild all 32 rows of the row blocking
// table (one memory write per cycle), check the start row and fetch its table
// entry, then a table or stack read per queen placed or removed (the read data of
// both memories is registered), with each solution counted in the step state; then
// find the start row exhausted and hand the count to the output register. When the
// start row lies past N-2 the check goes straight to the hand-over. The engine
// returns to idle before the next beat is accepted.
// The output register frees the engine: s_tready returns high while a result
// still waits on a stalled m_tready; the next result holds until that slot empties.
// Reset (aresetn low, synchronous) drops m_tvalid, returns to idle and sets
// board_size to 16. The memories need no clearing: each item writes before reads.
module nqueens_constellation_counter
    import nqcc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_W-1:0]      cfg_wdata,   // board_size
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // left_diag_mask[31:0], right_diag_mask[63:32], column_mask[95:64],
    // start_row[100:96], queen_j[105:101], queen_k[110:106], queen_l[115:111], zero pad
    input  logic [IN_W-1:0]       s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [COUNT_W-1:0]    m_tdata      // solution_count[47:0]
);

    in_item_t   s_item;
    tbl_req_t   tbl_req;
    mask_t      tbl_rdata;
    stk_req_t   stk_req;
    stk_entry_t stk_rdata;

    assign s_item = in_item_t'(s_tdata);

    nqcc_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_item    (s_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_count   (m_tdata),
        .tbl_req   (tbl_req),
        .tbl_rdata (tbl_rdata),
        .stk_req   (stk_req),
        .stk_rdata (stk_rdata)
    );

    nqcc_table_ram u_table (
        .aclk  (aclk),
        .req   (tbl_req),
        .rdata (tbl_rdata)
    );

    nqcc_stack_ram u_stack (
        .aclk  (aclk),
        .req   (stk_req),
        .rdata (stk_rdata)
    );

endmodule

// ===== sv/nqcc_checker.sv =====
// Port-level checks for the N-queens constellation counter, bound to the top level.
// Depends on nqcc_pkg and nqueens_constellation_counter.
module nqcc_checker
    import nqcc_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [COUNT_W-1:0] m_tdata
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Reset drops the result channel.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // One item in flight: the input side closes after an accepted beat.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat accepted while busy");

    // A result only appears from the busy engine, never straight from idle.
    a_result_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without work");

endmodule

bind nqueens_constellation_counter nqcc_checker u_nqcc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/tb.sv =====
// Self-checking bench for nqueens_constellation_counter: constellation beats in, counts out.
// Needs nqcc_pkg and the counter RTL; expected counts come from an in-bench backtracking
// predictor or typed entries; directed table first, then step-bounded random constellations.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nqcc_pkg::*;

    localparam int          NPROBES      = 18;
    localparam int          NPHASES      = 12;
    localparam int          PER_PHASE    = 7;
    localparam int unsigned STEP_CAP     = 2500;
    localparam int unsigned DIRECTED_CAP = 1000000;

    typedef struct {
        int     board;
        mask_t  ld;
        mask_t  rd;
        mask_t  col;
        row_t   start;
        row_t   j;
        row_t   k;
        row_t   l;
        bit     typed;
        count_t want;
    } probe_t;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [CFG_W-1:0]   cfg_wdata = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata   = '0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [COUNT_W-1:0] m_tdata;

    count_t pending_counts[$];
    size_t  board_now = BOARD_RESET;
    int     mismatches = 0;
    int     stall_left = 0;
    bit     quiet = 1'b0;

    // board, ld, rd, col, start, j, k, l, typed, want
    probe_t probes[NPROBES] = '{
        '{16, '1, '1, '1, 0, 0, 0, 0, 1'b1, 0},
        '{16, 0, 0, 0, 31, 31, 31, 31, 1'b1, 0},
        '{16, 0, 0, 0, 14, 3, 5, 9, 1'b0, 0},
        '{16, 32'h0000_F0F0, 32'h0F0F_0000, 0, 13, 7, 13, 13, 1'b0, 0},
        '{16, 0, 0, 32'h0000_00FF, 12, 2, 4, 15, 1'b0, 0},
        '{16, 32'h8000_0001, 32'h8000_0001, 0, 13, 20, 20, 25, 1'b0, 0},
        '{0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 0},
        '{0, 0, 0, 0, 5, 1, 2, 3, 1'b1, 0},
        '{0, 0, 0, 0, 1, 31, 31, 31, 1'b0, 0},
        '{5, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0014, 0, 4, 1, 2, 1'b0, 0},
        '{63, 0, 0, 0, 31, 0, 0, 0, 1'b1, 0},
        '{63, 0, 0, 0, 30, 31, 0, 31, 1'b0, 0},
        '{63, 0, 0, '1, 29, 16, 17, 18, 1'b0, 0},
        '{33, 32'h5555_5555, 32'h5555_5555, 32'h3333_3333, 28, 5, 28, 3, 1'b0, 0},
        '{32, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 30, 10, 30, 30, 1'b0, 0},
        '{6, '1, '1, '1, 4, 0, 0, 0, 1'b1, 0},
        '{6, 0, 0, 0, 0, 2, 1, 3, 1'b0, 0},
        '{8, 0, 0, 0, 0, 0, 0, 0, 1'b0, 0}
    };

    int phase_boards[NPHASES] = '{7, 32, 9, 0, 12, 63, 16, 6, 20, 8, 33, 10};

    nqueens_constellation_counter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int board_of(size_t cfg);
        int n;
        n = int'(cfg);
        if (n < MIN_BOARD) n = MIN_BOARD;
        if (n > MAX_BOARD) n = MAX_BOARD;
        return n;
    endfunction

    function automatic mask_t shift_up(mask_t x, int s);
        return (s < 0 || s > 31) ? '0 : x << s;
    endfunction

    function automatic mask_t shift_down(mask_t x, int s);
        return (s < 0 || s > 31) ? '0 : x >> s;
    endfunction

    // Count completions of one constellation; give up once the search exceeds cap steps.
    task automatic count_completions(input size_t cfg, input in_item_t it,
                                     input int unsigned cap,
                                     output count_t cnt, output bit too_long);
        mask_t       blk [MAX_BOARD];
        mask_t       stk_q [MAX_BOARD];
        mask_t       stk_free [MAX_BOARD];
        mask_t       top_bit, lbot, rbot, ltop, rtop, v;
        mask_t       ld, rd, col, freem, q, lsp, rsp;
        int          n, j, k, l, start, row, a;
        int unsigned steps;
        n        = board_of(cfg);
        j        = int'(it.queen_j);
        k        = int'(it.queen_k);
        l        = int'(it.queen_l);
        start    = int'(it.start_row);
        cnt      = '0;
        too_long = 1'b0;
        steps    = 0;

        top_bit = shift_up(mask_t'(1), n - 1);
        lbot    = shift_down(top_bit, j) | shift_down(top_bit, l);
        rbot    = shift_down(top_bit, j) | shift_down(top_bit, n - 1 - k);
        ltop    = shift_down(top_bit, k);
        rtop    = shift_up(mask_t'(1), l);

        for (a = 0; a < MAX_BOARD; a++) begin
            v = '0;
            if (a < n) begin
                if (a == k || a == l) begin
                    // border queen rows: wrapping sum when both land on one row
                    if (a == k) v = v + ~top_bit;
                    if (a == l) v = v + ~mask_t'(1);
                end else begin
                    v = shift_down(lbot, n - 1 - a) | shift_up(rbot, n - 1 - a)
                      | shift_up(ltop, a) | shift_down(rtop, a) | top_bit | mask_t'(1);
                end
            end
            blk[a] = v;
        end

        if (start > n - 2) return;

        ld = it.left_diag_mask & ~shift_up(ltop, start);
        rd = it.right_diag_mask;
        if (l != n - 1) rd = rd & ~shift_down(rtop, start);
        col   = ~(top_bit - mask_t'(2)) ^ it.column_mask;
        lsp   = '0;
        rsp   = '0;
        row   = start;
        freem = ~(ld | rd | col | blk[row]);

        while (row >= start) begin
            steps++;
            if (steps > cap) begin
                too_long = 1'b1;
                return;
            end
            if (freem != '0) begin
                if (row == n - 2) begin
                    if (cnt != COUNT_MAX) cnt = cnt + 1'b1;
                    freem = '0;
                end else begin
                    q              = freem & (~freem + mask_t'(1));
                    stk_q[row]     = q;
                    stk_free[row]  = freem ^ q;
                    row++;
                    // keep the diagonal bits that leave the word
                    lsp   = {lsp[30:0], ld[31]};
                    rsp   = {rd[0], rsp[31:1]};
                    ld    = (ld | q) << 1;
                    rd    = (rd | q) >> 1;
                    col   = col ^ q;
                    freem = ~(blk[row] | ld | rd | col);
                end
            end else begin
                row--;
                if (row >= start) begin
                    q     = stk_q[row];
                    freem = stk_free[row];
                    ld    = ((ld >> 1) | {lsp[0], 31'b0}) & ~q;
                    rd    = ((rd << 1) | {31'b0, rsp[31]}) & ~q;
                    lsp   = lsp >> 1;
                    rsp   = rsp << 1;
                    col   = col ^ q;
                end
            end
        end
    endtask

    function automatic mask_t rand_mask();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom & $urandom;
            2: return $urandom | $urandom;
            default: return $urandom | $urandom | $urandom;
        endcase
    endfunction

    function automatic row_t rand_row(int n);
        if ($urandom_range(0, 3) != 0) return row_t'($urandom_range(0, n - 1));
        return row_t'($urandom_range(0, 31));
    endfunction

    // Random constellation whose search stays within the step budget.
    task automatic pick_constellation(input size_t cfg, output in_item_t it,
                                      output count_t want);
        int n, deep, depth, tries;
        bit too_long;
        n  = board_of(cfg);
        it = '0;
        if ($urandom_range(0, 9) == 0) begin
            // start row beyond the counting row
            it.left_diag_mask  = $urandom;
            it.right_diag_mask = $urandom;
            it.column_mask     = $urandom;
            it.start_row       = row_t'($urandom_range(n - 1, 31));
            it.queen_j         = row_t'($urandom_range(0, 31));
            it.queen_k         = row_t'($urandom_range(0, 31));
            it.queen_l         = row_t'($urandom_range(0, 31));
            count_completions(cfg, it, STEP_CAP, want, too_long);
            return;
        end
        tries = 0;
        forever begin
            deep = ((n <= 9) ? n - 2 : 6) - tries / 6;
            if (deep < 0) deep = 0;
            depth              = $urandom_range(0, deep);
            it.start_row       = row_t'(n - 2 - depth);
            it.left_diag_mask  = rand_mask();
            it.right_diag_mask = rand_mask();
            it.column_mask     = rand_mask();
            it.queen_j         = rand_row(n);
            it.queen_k         = rand_row(n);
            it.queen_l         = rand_row(n);
            count_completions(cfg, it, STEP_CAP, want, too_long);
            if (!too_long) break;
            tries++;
        end
    endtask

    task automatic send_constellation(in_item_t it, count_t want, bit hold);
        int gap;
        s_tdata  <= it;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_counts.push_back(want);
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
        if (!hold || gap != 0) s_tvalid <= 1'b0;
        repeat (gap) @(posedge aclk);
    endtask

    // Write board_size once every pending count has come back.
    task automatic set_board(size_t value);
        while (pending_counts.size() != 0) @(posedge aclk);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        board_now = value;
    endtask

    task automatic flag_mismatch(string what, count_t got, count_t want);
        mismatches++;
        $display("%0t ns: %s: solution_count %0d, predicted %0d", $time, what, got, want);
    endtask

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 18) - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready   <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_counts.size() == 0) begin
                flag_mismatch("result beat with nothing pending", m_tdata, '0);
            end else begin
                count_t want;
                want = pending_counts.pop_front();
                if (m_tdata !== want) flag_mismatch("count mismatch", m_tdata, want);
            end
        end
    end

    initial begin
        int       i, p;
        in_item_t it;
        count_t   want;
        bit       too_long;
        bit       hold;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < NPROBES; i++) begin
            if (probes[i].board != int'(board_now)) set_board(size_t'(probes[i].board));
            it                 = '0;
            it.left_diag_mask  = probes[i].ld;
            it.right_diag_mask = probes[i].rd;
            it.column_mask     = probes[i].col;
            it.start_row       = probes[i].start;
            it.queen_j         = probes[i].j;
            it.queen_k         = probes[i].k;
            it.queen_l         = probes[i].l;
            if (probes[i].typed) begin
                want = probes[i].want;
            end else begin
                count_completions(board_now, it, DIRECTED_CAP, want, too_long);
            end
            hold = (i + 1 < NPROBES) && (probes[i + 1].board == int'(board_now));
            send_constellation(it, want, hold);
        end

        for (p = 0; p < NPHASES; p++) begin
            quiet = (p >= NPHASES - 2);
            set_board(size_t'(phase_boards[p]));
            for (i = 0; i < PER_PHASE; i++) begin
                pick_constellation(board_now, it, want);
                send_constellation(it, want, i + 1 < PER_PHASE);
            end
        end

        while (pending_counts.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (mismatches == 0) begin
            $display("** nqueens_constellation_counter: PASSED **");
        end else begin
            $display("** nqueens_constellation_counter: FAILED **");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("** nqueens_constellation_counter: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/nqcc_pkg.sv
sv/nqcc_table_ram.sv
sv/nqcc_stack_ram.sv
sv/nqcc_engine.sv
sv/nqueens_constellation_counter.sv
sv/nqcc_checker.sv
tb/tb.sv
